// ----- hw/rtl/pad_input_decoder_edge_events_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the pad input decoder
// Shared same-cycle and next-cycle property forms; the using module
// must have signals named clock and reset in scope.
// ---------------------------------------------------------------------------
`ifndef PAD_INPUT_DECODER_EDGE_EVENTS_ASSERT_SVH
`define PAD_INPUT_DECODER_EDGE_EVENTS_ASSERT_SVH

// check cons in the same cycle as ante
`define PIDE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define PIDE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pide_pkg.sv -----
// ---------------------------------------------------------------------------
// pide_pkg
// Shared codes, masks and record types of the pad input decoder.
// ---------------------------------------------------------------------------
package pide_pkg;

   localparam int BUTTON_W   = 32;
   localparam int ANALOG_W   = 32;
   localparam int PAD_TYPE_W = 2;
   localparam int MASK_W     = 5;
   localparam int KIND_W     = 3;
   localparam int NUM_EVENTS = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 72;

   // pad types
   localparam logic [PAD_TYPE_W-1:0] PAD_PLAIN    = 2'd0;
   localparam logic [PAD_TYPE_W-1:0] PAD_EXTENDED = 2'd1;
   localparam logic [PAD_TYPE_W-1:0] PAD_FOURTEEN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_TYPE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_MASK = 1'd1;

   localparam logic [MASK_W-1:0] EVENT_MASK_RESET = 5'd31;

   // event kinds, also the bit positions in the pending mask
   localparam logic [KIND_W-1:0] EV_PRESSED  = 3'd0;
   localparam logic [KIND_W-1:0] EV_RELEASED = 3'd1;
   localparam logic [KIND_W-1:0] EV_UPDATE   = 3'd2;
   localparam logic [KIND_W-1:0] EV_ARRIVED  = 3'd3;
   localparam logic [KIND_W-1:0] EV_SETTING  = 3'd4;

   // button field masks
   localparam logic [BUTTON_W-1:0] EXT_MASK_HI  = 32'hFE00_0000;
   localparam logic [BUTTON_W-1:0] EXT_MASK_MID = 32'h01E0_0000;
   localparam logic [BUTTON_W-1:0] EXT_MASK_LO  = 32'h001C_0000;
   localparam logic [BUTTON_W-1:0] FOURTEEN_MASK = 32'hFFFC_0000;
   localparam int PLAIN_SHIFT    = 19;
   localparam int FOURTEEN_SHIFT = 11;

   // one decoded sample waiting for its events to go out
   typedef struct packed {
      logic [NUM_EVENTS-1:0] pend;
      logic [BUTTON_W-1:0]   cur;
      logic [BUTTON_W-1:0]   down;
      logic [BUTTON_W-1:0]   up;
      logic                  analog_valid;
      logic [ANALOG_W-1:0]   analog;
   } item_type;

   // one result
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BUTTON_W-1:0] buttons;
      logic                analog_valid;
      logic [ANALOG_W-1:0] analog;
      logic                last;
   } rsp_type;

endpackage

// ----- hw/rtl/pide_decode.sv -----
// ---------------------------------------------------------------------------
// pide_decode
// Decode one raw sample into buttons and analog word, track the previous
// sample and form the mask of events it causes.
// ---------------------------------------------------------------------------
module pide_decode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [pide_pkg::REQ_DATA_W-1:0]    raw,
   input  logic                               recover_lost,
   input  logic [pide_pkg::PAD_TYPE_W-1:0]    pad_type,
   input  logic [pide_pkg::MASK_W-1:0]        event_mask,
   output pide_pkg::item_type                 item
);
   import pide_pkg::*;

   logic [7:0]          b0, b1, b2, b3, b4, b5, b6;
   logic [BUTTON_W-1:0] w;
   logic [BUTTON_W-1:0] cur;
   logic [ANALOG_W-1:0] analog;
   logic                valid;
   logic [BUTTON_W-1:0] down, up;
   logic [BUTTON_W-1:0] prev_buttons_ff, prev_buttons_in;
   logic [ANALOG_W-1:0] prev_analog_ff, prev_analog_in;

   assign {b6, b5, b4, b3, b2, b1, b0} = raw;
   assign w = {b0, b1, b2, 8'h00};

   always_comb begin
      cur    = '0;
      analog = '0;
      valid  = 1'b0;
      unique case (pad_type)
         PAD_PLAIN: begin
            cur = {16'h0000, b0, b1} << PLAIN_SHIFT;
         end
         PAD_EXTENDED: begin
            valid  = 1'b1;
            cur    = ((w << 3) & EXT_MASK_HI) | ((w << 6) & EXT_MASK_MID)
                   | ((w >> 1) & EXT_MASK_LO);
            analog = {b3, b4, b5, b6};
         end
         PAD_FOURTEEN: begin
            cur = ({8'h00, b0, b1, b2} << FOURTEEN_SHIFT) & FOURTEEN_MASK;
         end
         default: begin
            cur = '0;
         end
      endcase
   end

   assign down = cur & ~prev_buttons_ff;
   assign up   = prev_buttons_ff & ~cur;

   always_comb begin
      item.pend              = '0;
      item.pend[EV_PRESSED]  = (down != '0) && event_mask[EV_PRESSED];
      item.pend[EV_RELEASED] = (up != '0) && event_mask[EV_RELEASED];
      item.pend[EV_UPDATE]   = recover_lost
                               || (((down | up) != '0) && event_mask[EV_UPDATE]);
      item.pend[EV_ARRIVED]  = event_mask[EV_ARRIVED];
      item.pend[EV_SETTING]  = (analog != prev_analog_ff) && event_mask[EV_SETTING];
      item.cur               = cur;
      item.down              = down;
      item.up                = up;
      item.analog_valid      = valid;
      item.analog            = analog;
   end

   assign prev_buttons_in = accept ? cur : prev_buttons_ff;
   assign prev_analog_in  = accept ? analog : prev_analog_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
         prev_analog_ff  <= '0;
      end else begin
         prev_buttons_ff <= prev_buttons_in;
         prev_analog_ff  <= prev_analog_in;
      end
   end

endmodule

// ----- hw/rtl/pide_emit.sv -----
// ---------------------------------------------------------------------------
// pide_emit
// Hold one decoded sample and move its pending events, lowest kind first,
// into the output register.
// ---------------------------------------------------------------------------
module pide_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  pide_pkg::item_type  item_new,
   output logic                item_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pide_pkg::rsp_type   rsp
);
   import pide_pkg::*;

   `include "pad_input_decoder_edge_events_assert.svh"

   item_type              item_ff, item_in;
   logic [NUM_EVENTS-1:0] sel;
   logic [NUM_EVENTS-1:0] pend_next;
   logic [KIND_W-1:0]     sel_kind;
   logic                  out_free;
   logic                  move;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // lowest pending event
   always_comb begin
      sel      = '0;
      sel_kind = EV_PRESSED;
      for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
         if (item_ff.pend[i]) begin
            sel      = '0;
            sel[i]   = 1'b1;
            sel_kind = KIND_W'(i);
         end
      end
   end

   assign pend_next = item_ff.pend & ~sel;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = (item_ff.pend != '0) && out_free;
   assign item_free = (item_ff.pend == '0) || (move && (pend_next == '0));

   always_comb begin
      item_in = item_ff;
      if (load) begin
         item_in = item_new;
      end else if (move) begin
         item_in.pend = pend_next;
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff;
      if (move) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = sel_kind;
         rsp_in.analog_valid = item_ff.analog_valid;
         rsp_in.analog       = item_ff.analog;
         rsp_in.last         = (pend_next == '0);
         case (sel_kind)
            EV_PRESSED:  rsp_in.buttons = item_ff.down;
            EV_RELEASED: rsp_in.buttons = item_ff.up;
            default:     rsp_in.buttons = item_ff.cur;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `PIDE_ASSERT_NOW(a_sel_onehot, 1'b1, $onehot0(sel), "more than one event selected")
   `PIDE_ASSERT_NEXT(a_move_fills, move, rsp_valid_ff, "moved event not in output register")
   `PIDE_ASSERT_NEXT(a_pend_hold, (item_ff.pend != '0) && !out_free, $stable(item_ff.pend),
                     "pending events changed while output stalled")
   `PIDE_ASSERT_NOW(a_last_pending, rsp_valid_ff && !rsp_ff.last, item_ff.pend != '0,
                    "non-final event shown with nothing pending")

endmodule

// ----- hw/rtl/pad_input_decoder_edge_events.sv -----
// ---------------------------------------------------------------------------
// pad_input_decoder_edge_events
// Decode raw pad samples into button words and emit edge and status events.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_     in         req_tvalid/tready    tdata byte0..byte6, tuser recover_lost
//   rsp_     out        rsp_tvalid/tready    tdata buttons+analog, tuser kind, tlast
//   csr_     in         csr_we (no wait)     csr_index, csr_wdata
//
// Each request yields zero to five responses, one per cycle while rsp_tready
// stays high, so a request occupies the event holding register until its
// last enabled event moves into the single output register. A request with no
// enabled event leaves the holding register free.
// At the accepting edge the request lands in the holding register, then its
// first event moves into the output register, where the first response is valid.
// A new request is accepted in the cycle the last event of the previous one
// moves into the output register, so requests run back to back.
// A stalled rsp_tready holds the output register and the pending events.
// Reset is synchronous: plain pad, all events on, prior sample and valid cleared.
//
module pad_input_decoder_edge_events (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pide_pkg::REQ_DATA_W-1:0]    req_tdata,  // byte0,byte1,..,byte6
   input  logic                               req_tuser,  // recover_lost
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // button_bits[31:0], analog_valid, stick_x, stick_y, right_shift,
   // left_shift, shuttle, zero fill
   output logic [pide_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [pide_pkg::KIND_W-1:0]        rsp_tuser,  // event_kind
   output logic                               rsp_tlast,
   // configuration writes
   input  logic                               csr_we,
   input  logic [pide_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pide_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pide_pkg::*;

   logic [PAD_TYPE_W-1:0] pad_type_ff, pad_type_in;
   logic [MASK_W-1:0]     event_mask_ff, event_mask_in;
   logic                  accept;
   logic                  item_free;
   item_type              item_new;
   rsp_type               rsp;

   // register writes; unlisted indexes do not exist with this index width
   always_comb begin
      pad_type_in   = pad_type_ff;
      event_mask_in = event_mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PAD_TYPE:   pad_type_in   = csr_wdata[PAD_TYPE_W-1:0];
            CSR_EVENT_MASK: event_mask_in = csr_wdata[MASK_W-1:0];
            default:        pad_type_in   = pad_type_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_type_ff   <= PAD_PLAIN;
         event_mask_ff <= EVENT_MASK_RESET;
      end else begin
         pad_type_ff   <= pad_type_in;
         event_mask_ff <= event_mask_in;
      end
   end

   // take a request whenever the holding register frees up this cycle
   assign req_tready = item_free;
   assign accept     = req_tvalid && item_free;

   pide_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .raw          (req_tdata),
      .recover_lost (req_tuser),
      .pad_type     (pad_type_ff),
      .event_mask   (event_mask_ff),
      .item         (item_new)
   );

   pide_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .item_new  (item_new),
      .item_free (item_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // analog fields are already zero unless the pad is extended
   assign rsp_tdata = {7'd0,
                       rsp.analog[7:0],
                       rsp.analog[11:8],
                       rsp.analog[15:12],
                       rsp.analog[23:16],
                       rsp.analog[31:24],
                       rsp.analog_valid,
                       rsp.buttons};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

// ----- verif/pad_event_checker.sv -----
// ---------------------------------------------------------------------------
// pad_event_checker
// Watches the request, response and register ports of the pad input decoder.
// It predicts the events of every accepted request and compares each
// accepted response, field by field, with the oldest predicted event.
// ---------------------------------------------------------------------------
module pad_event_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pide_pkg::REQ_DATA_W-1:0] req_tdata,  // byte0,byte1,..,byte6
   input  logic                            req_tuser,  // recover_lost
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // button_bits[31:0], analog_valid, stick_x, stick_y, right_shift,
   // left_shift, shuttle, zero fill
   input  logic [pide_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [pide_pkg::KIND_W-1:0]     rsp_tuser,  // event_kind
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [pide_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pide_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              events_due
);
   import pide_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BUTTON_W-1:0] buttons;
      logic                analog_valid;
      logic [7:0]          stick_x;
      logic [7:0]          stick_y;
      logic [3:0]          right_shift;
      logic [3:0]          left_shift;
      logic [7:0]          shuttle;
      logic                last;
   } pad_event_type;

   logic [PAD_TYPE_W-1:0] pad_type;
   logic [MASK_W-1:0]     event_mask;
   logic [BUTTON_W-1:0]   held_buttons;
   logic [ANALOG_W-1:0]   held_analog;
   pad_event_type         events_q[$];

   function automatic pad_event_type make_event(input logic [KIND_W-1:0] kind,
                                                input logic [BUTTON_W-1:0] bits,
                                                input logic valid,
                                                input logic [ANALOG_W-1:0] analog);
      pad_event_type ev;
      ev.kind         = kind;
      ev.buttons      = bits;
      ev.analog_valid = valid;
      ev.stick_x      = valid ? analog[31:24] : 8'h00;
      ev.stick_y      = valid ? analog[23:16] : 8'h00;
      ev.right_shift  = valid ? analog[15:12] : 4'h0;
      ev.left_shift   = valid ? analog[11:8]  : 4'h0;
      ev.shuttle      = valid ? analog[7:0]   : 8'h00;
      ev.last         = 1'b0;
      return ev;
   endfunction

   // Decode one sample, derive its edges and queue the enabled events.
   function automatic void predict_events(input logic [REQ_DATA_W-1:0] data,
                                          input logic recover);
      logic [7:0]          b0, b1, b2;
      logic [BUTTON_W-1:0] word, cur, down, up;
      logic [ANALOG_W-1:0] analog;
      logic                valid;
      pad_event_type       found[$];
      b0     = data[7:0];
      b1     = data[15:8];
      b2     = data[23:16];
      cur    = '0;
      analog = '0;
      valid  = (pad_type == PAD_EXTENDED);
      case (pad_type)
         PAD_PLAIN: begin
            cur = {16'h0000, b0, b1} << PLAIN_SHIFT;
         end
         PAD_EXTENDED: begin
            word   = {b0, b1, b2, 8'h00};
            cur    = ((word << 3) & EXT_MASK_HI) | ((word << 6) & EXT_MASK_MID)
                   | ((word >> 1) & EXT_MASK_LO);
            analog = {data[31:24], data[39:32], data[47:40], data[55:48]};
         end
         PAD_FOURTEEN: begin
            cur = ({8'h00, b0, b1, b2} << FOURTEEN_SHIFT) & FOURTEEN_MASK;
         end
         default: begin
            cur = '0;
         end
      endcase
      down = cur & ~held_buttons;
      up   = held_buttons & ~cur;
      if (down != '0 && event_mask[EV_PRESSED])
         found.push_back(make_event(EV_PRESSED, down, valid, analog));
      if (up != '0 && event_mask[EV_RELEASED])
         found.push_back(make_event(EV_RELEASED, up, valid, analog));
      if (recover || ((down | up) != '0 && event_mask[EV_UPDATE]))
         found.push_back(make_event(EV_UPDATE, cur, valid, analog));
      if (event_mask[EV_ARRIVED])
         found.push_back(make_event(EV_ARRIVED, cur, valid, analog));
      if (analog != held_analog && event_mask[EV_SETTING])
         found.push_back(make_event(EV_SETTING, cur, valid, analog));
      held_buttons = cur;
      held_analog  = analog;
      if (found.size() > 0)
         found[found.size() - 1].last = 1'b1;
      foreach (found[i])
         events_q.push_back(found[i]);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      pad_event_type want;
      if (reset) begin
         pad_type       = PAD_PLAIN;
         event_mask     = EVENT_MASK_RESET;
         held_buttons   = '0;
         held_analog    = '0;
         mismatch_count = 0;
         events_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAD_TYPE:   pad_type   = csr_wdata[PAD_TYPE_W-1:0];
               CSR_EVENT_MASK: event_mask = csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (events_q.size() == 0) begin
               $error("unexpected response: kind %0d buttons %0h", rsp_tuser,
                      rsp_tdata[31:0]);
               mismatch_count++;
            end else begin
               want = events_q.pop_front();
               compare_field("event_kind", 32'(want.kind), 32'(rsp_tuser));
               compare_field("button_bits", want.buttons, rsp_tdata[31:0]);
               compare_field("analog_valid", 32'(want.analog_valid), 32'(rsp_tdata[32]));
               compare_field("stick_x", 32'(want.stick_x), 32'(rsp_tdata[40:33]));
               compare_field("stick_y", 32'(want.stick_y), 32'(rsp_tdata[48:41]));
               compare_field("right_shift", 32'(want.right_shift), 32'(rsp_tdata[52:49]));
               compare_field("left_shift", 32'(want.left_shift), 32'(rsp_tdata[56:53]));
               compare_field("shuttle", 32'(want.shuttle), 32'(rsp_tdata[64:57]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            predict_events(req_tdata, req_tuser);
      end
      events_due <= events_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives pad samples and register writes into the pad input decoder, with
// random idling on both sides and one long response stall, and leaves the
// event prediction and comparison to pad_event_checker.
// ---------------------------------------------------------------------------
module testbench;
   import pide_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 120;   // response stall that backs up the requests
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 29;
   localparam int SETTLE_CYCLES = 4;     // covers requests that raise no event

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int   mismatch_count;
   int   events_due;
   int   cycle_count    = 0;
   logic calm           = 1'b0;   // no idling on either side
   logic hold_requested = 1'b0;   // ask the receiver for one long stall

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pad_input_decoder_edge_events DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pad_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .events_due     (events_due)
   );

   // Offer one request, idling first now and then, and return at the edge
   // that accepts it. Keep tvalid high between back-to-back requests.
   task automatic send_sample(input logic [REQ_DATA_W-1:0] data, input logic recover);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= recover;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and wait until every predicted event has come out, plus a
   // settling wait for a request that raises no event at all.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (events_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: mostly ready, stalls in short random bursts, and holds off
   // once for a long stretch while the sender keeps offering requests.
   initial begin
      forever begin
         if (hold_requested) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_requested = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if it overstays the cycle budget.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [REQ_DATA_W-1:0] sample;
      logic [PAD_TYPE_W-1:0] pad_sel;
      logic [MASK_W-1:0]     mask_sel;
      int                    bit_idx;
      int                    mode;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Plain pad with the reset configuration: no change, full press,
      // forced update without change, full release, top bit alone.
      send_sample(56'h00_00_00_00_00_00_00, 1'b0);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b1);
      send_sample(56'h00_00_00_00_00_00_00, 1'b0);
      send_sample(56'h00_00_00_00_00_00_80, 1'b0);

      // Extended pad: analog data appears, holds, moves, and goes away.
      settle();
      write_reg(CSR_PAD_TYPE, CSR_DATA_W'(PAD_EXTENDED));
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'h5A_A5_34_12_FF_FF_FF, 1'b0);
      send_sample(56'h00_00_00_00_00_00_00, 1'b0);
      send_sample(56'h01_00_00_FF_80_00_01, 1'b1);

      // Fourteen-button pad, selected by a value with stray upper bits.
      settle();
      write_reg(CSR_PAD_TYPE, 5'b11110);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'h00_00_00_00_80_00_00, 1'b0);
      send_sample(56'h00_00_00_00_00_00_00, 1'b0);

      // Unused pad type: everything decodes to zero.
      settle();
      write_reg(CSR_PAD_TYPE, 5'b00011);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b1);

      // All events masked: only a forced update gets through.
      settle();
      write_reg(CSR_PAD_TYPE, CSR_DATA_W'(PAD_EXTENDED));
      write_reg(CSR_EVENT_MASK, '0);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'h00_00_00_00_00_00_00, 1'b1);
      send_sample(56'h12_34_56_78_9A_BC_DE, 1'b0);

      // Single and paired mask bits on the plain pad.
      settle();
      write_reg(CSR_PAD_TYPE, CSR_DATA_W'(PAD_PLAIN));
      write_reg(CSR_EVENT_MASK, 5'b00001);
      send_sample(56'hFF_FF_FF_FF_FF_FF_FF, 1'b0);
      send_sample(56'h00_00_00_00_00_00_00, 1'b0);
      settle();
      write_reg(CSR_EVENT_MASK, 5'b10010);
      send_sample(56'h00_00_00_00_00_A5_C3, 1'b0);
      send_sample(56'h00_00_00_00_00_00_00, 1'b0);

      // Random phases: each picks a setting, then mixes fresh samples,
      // small edits of the last sample and plain repeats.
      sample = '0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         pad_sel = PAD_TYPE_W'($urandom_range(0, 3));
         if (phase == 0 || phase == RANDOM_PHASES - 1)
            pad_sel = PAD_EXTENDED;
         else if (phase == 1)
            pad_sel = PAD_PLAIN;
         mask_sel = MASK_W'($urandom_range(0, 31));
         if (phase == 0 || phase == RANDOM_PHASES - 1 || $urandom_range(0, 3) == 0)
            mask_sel = EVENT_MASK_RESET;
         else if (phase == 1)
            mask_sel = '0;
         write_reg(CSR_PAD_TYPE, {3'($urandom_range(0, 7)), pad_sel});
         write_reg(CSR_EVENT_MASK, mask_sel);
         calm = (phase == RANDOM_PHASES - 1);
         if (phase == 0)
            hold_requested = 1'b1;
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
               sample = REQ_DATA_W'({$urandom, $urandom});
            end else if (mode < 8) begin
               repeat ($urandom_range(1, 3)) begin
                  bit_idx         = $urandom_range(0, REQ_DATA_W - 1);
                  sample[bit_idx] = ~sample[bit_idx];
               end
            end
            send_sample(sample, $urandom_range(0, 7) == 0);
         end
      end

      settle();
      if (mismatch_count == 0 && events_due == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
